FILE: rtl/core/sv39ptw_pkg.sv
// ============================================================================
// sv39ptw_pkg
// Shared types and constants for the Sv39 page-table walker: field widths,
// opcodes, status codes and the controller/datapath command structs.
// ============================================================================
package sv39ptw_pkg;

   // field widths
   localparam int OPCODE_W = 1;
   localparam int ROOT_W   = 4;
   localparam int WIDX_W   = 13;
   localparam int PTE_W    = 64;
   localparam int VA_W     = 39;
   localparam int PA_W     = 56;
   localparam int STATUS_W = 3;

   // Sv39 layout
   localparam int IDX_W        = 9;
   localparam int PAGE_ENTRIES = 512;
   localparam int PPN_W        = 44;
   localparam int PPN_LSB      = 10;
   localparam int PAGE_SHIFT   = 12;
   localparam int PTE_V_BIT    = 0;
   localparam int PTE_U_BIT    = 4;

   // addresses at or above 2**VA_LIMIT_BITS are rejected
   localparam int VA_LIMIT_BITS = 38;

   localparam int TABLE_PAGES_DEF = 16;

   localparam logic [OPCODE_W-1:0] OP_WRITE     = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_TRANSLATE = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_UNMAPPED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_USER = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OUTSIDE  = 3'd4;

   // which step of an item the datapath is evaluating
   typedef enum logic [1:0] {
      PH_REQ,
      PH_L2,
      PH_L1,
      PH_L0
   } phase_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_L2,
      S_L1,
      S_L0
   } ctrl_state_type;

   typedef struct packed {
      logic      accept;    // input word taken this cycle
      logic      rd_en;     // issue a table read
      logic      clr_en;    // clear one store entry
      logic      out_load;  // load the result register
      phase_type phase;
   } dp_cmd_type;

   typedef struct packed {
      logic done;      // current step ends the item
      logic clr_last;  // clear pass at its last entry
   } dp_stat_type;

endpackage

FILE: rtl/core/sv39_page_table_walker_top.sv
// ============================================================================
// sv39_page_table_walker_top
// Sv39 three-level page-table walker over a local page-table store.
// ============================================================================
// Result: a write, range or root fault loads the result register at accept; a walk
//   does one registered store read per level, or ends at a level-2 or level-1 fault.
// Throughput: one word in flight, one write per cycle; a walk holds req_stall high,
//   and a result held by rsp_stall keeps req_stall high until it is taken.
// Reset (synchronous): clears every store entry, one entry per cycle, with req_stall
//   high throughout.
module sv39_page_table_walker_top
   import sv39ptw_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ROOT_W-1:0]   req_root_page,
   input  logic [WIDX_W-1:0]   req_word_index,
   input  logic [PTE_W-1:0]    req_write_data,
   input  logic [VA_W-1:0]     req_vaddr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [PA_W-1:0]     rsp_phys_addr,
   output logic [STATUS_W-1:0] rsp_status
);

   dp_cmd_type  cmd;
   dp_stat_type st;

   sv39ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .st        (st)
   );

   sv39ptw_dp #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_opcode     (req_opcode),
      .req_root_page  (req_root_page),
      .req_word_index (req_word_index),
      .req_write_data (req_write_data),
      .req_vaddr      (req_vaddr),
      .rsp_phys_addr  (rsp_phys_addr),
      .rsp_status     (rsp_status)
   );

endmodule

FILE: rtl/core/sv39ptw_dp.sv
// ============================================================================
// sv39ptw_dp
// Datapath: page-table store, clear counter, walk registers, per-step
// fault checks and the result register.
// ============================================================================
module sv39ptw_dp
   import sv39ptw_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_stat_type         st,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ROOT_W-1:0]   req_root_page,
   input  logic [WIDX_W-1:0]   req_word_index,
   input  logic [PTE_W-1:0]    req_write_data,
   input  logic [VA_W-1:0]     req_vaddr,
   output logic [PA_W-1:0]     rsp_phys_addr,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int DEPTH  = TABLE_PAGES * PAGE_ENTRIES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int PG_W   = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int WX_W   = (ADDR_W > WIDX_W) ? ADDR_W : WIDX_W;

   logic [PTE_W-1:0] store_mem [0:DEPTH-1];

   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]    vpn1_ff, vpn0_ff;
   logic [PTE_W-1:0]    rdata_ff;
   logic [PA_W-1:0]     pa_ff;
   logic [STATUS_W-1:0] status_ff;

   logic                mem_we;
   logic [ADDR_W-1:0]   mem_waddr;
   logic [PTE_W-1:0]    mem_wdata;
   logic [ADDR_W-1:0]   mem_raddr;
   logic [PG_W+IDX_W-1:0] raddr_full;
   logic [PG_W-1:0]     rd_page;
   logic [IDX_W-1:0]    rd_idx;
   logic [WX_W-1:0]     widx_ext;

   logic [PPN_W-1:0]    pte_ppn;
   logic                pte_v, pte_u;
   logic                widx_ok, va_ok, root_ok, ppn_ok;
   logic [PA_W-1:0]     res_pa;
   logic [STATUS_W-1:0] res_status;
   logic                step_done;
   logic                clr_last;

   assign pte_ppn = rdata_ff[PPN_LSB +: PPN_W];
   assign pte_v   = rdata_ff[PTE_V_BIT];
   assign pte_u   = rdata_ff[PTE_U_BIT];

   assign widx_ok = 32'(req_word_index) < 32'(DEPTH);
   assign va_ok   = (req_vaddr >> VA_LIMIT_BITS) == '0;
   assign root_ok = PPN_W'(req_root_page) < PPN_W'(TABLE_PAGES);
   assign ppn_ok  = pte_ppn < PPN_W'(TABLE_PAGES);

   // store write: clear pass or a write word
   assign widx_ext  = WX_W'(req_word_index);
   assign mem_we    = cmd.clr_en || (cmd.accept && req_opcode == OP_WRITE && widx_ok);
   assign mem_waddr = cmd.clr_en ? clr_ff : widx_ext[ADDR_W-1:0];
   assign mem_wdata = cmd.clr_en ? '0 : req_write_data;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   // read address: root and VPN[2] on accept, else next table from last PTE
   always_comb begin
      rd_page = PG_W'(pte_ppn);
      rd_idx  = vpn0_ff;
      unique case (cmd.phase)
         PH_REQ: begin
            rd_page = PG_W'(req_root_page);
            rd_idx  = req_vaddr[PAGE_SHIFT + 2*IDX_W +: IDX_W];
         end
         PH_L2: rd_idx = vpn1_ff;
         PH_L1: rd_idx = vpn0_ff;
         PH_L0: rd_idx = vpn0_ff;
         default: rd_idx = vpn0_ff;
      endcase
      raddr_full = {rd_page, rd_idx};
      mem_raddr  = raddr_full[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   // clear counter
   assign clr_in   = cmd.clr_en ? clr_ff + 1'b1 : clr_ff;
   assign clr_last = clr_ff == ADDR_W'(DEPTH - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         vpn1_ff <= req_vaddr[PAGE_SHIFT + IDX_W +: IDX_W];
         vpn0_ff <= req_vaddr[PAGE_SHIFT +: IDX_W];
      end
   end

   // step result and whether it ends the item
   always_comb begin
      res_pa     = '0;
      res_status = STAT_OK;
      step_done  = 1'b1;
      unique case (cmd.phase)
         PH_REQ: begin
            priority if (req_opcode == OP_WRITE) begin
               res_status = widx_ok ? STAT_OK : STAT_OUTSIDE;
            end else if (!va_ok) begin
               res_status = STAT_RANGE;
            end else if (!root_ok) begin
               res_status = STAT_OUTSIDE;
            end else begin
               step_done = 1'b0;
            end
         end
         PH_L2, PH_L1: begin
            step_done  = !pte_v || !ppn_ok;
            res_status = pte_v ? STAT_OUTSIDE : STAT_UNMAPPED;
         end
         PH_L0: begin
            priority if (!pte_v) begin
               res_status = STAT_UNMAPPED;
            end else if (!pte_u) begin
               res_status = STAT_NOT_USER;
            end else begin
               res_pa = {pte_ppn, PAGE_SHIFT'(0)};
            end
         end
         default: step_done = 1'b1;
      endcase
   end

   assign st = {step_done, clr_last};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pa_ff     <= res_pa;
         status_ff <= res_status;
      end
   end

   assign rsp_phys_addr = pa_ff;
   assign rsp_status    = status_ff;

   // table reads only ever target pages inside the store
   a_next_page_in_store: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && (cmd.phase == PH_L2 || cmd.phase == PH_L1)) |-> ppn_ok)
      else $error("walk read of a page outside the store");

   a_root_read_checked: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.phase == PH_REQ) |->
         (va_ok && root_ok && req_opcode == OP_TRANSLATE))
      else $error("root read issued for a faulting or write word");

   a_clear_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_en |-> !(cmd.accept || cmd.rd_en || cmd.out_load))
      else $error("store access during clear pass");

endmodule

FILE: rtl/core/sv39ptw_ctrl.sv
// ============================================================================
// sv39ptw_ctrl
// Controller: clear pass after reset, walk sequencing over three levels,
// input stall and result valid.
// ============================================================================
module sv39ptw_ctrl
   import sv39ptw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output dp_cmd_type  cmd,
   input  dp_stat_type st
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // result slot can take a new word this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd.accept   = 1'b0;
      cmd.rd_en    = 1'b0;
      cmd.clr_en   = 1'b0;
      cmd.out_load = 1'b0;
      cmd.phase    = PH_REQ;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (st.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               cmd.accept = 1'b1;
               if (st.done) begin
                  cmd.out_load = 1'b1;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_L2;
               end
            end
         end
         S_L2, S_L1: begin
            cmd.phase = (state_ff == S_L2) ? PH_L2 : PH_L1;
            if (st.done) begin
               if (out_free) begin
                  cmd.out_load = 1'b1;
                  state_in     = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = (state_ff == S_L2) ? S_L1 : S_L0;
            end
         end
         S_L0: begin
            cmd.phase = PH_L0;
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input taken while a walk or clear is in progress");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a word not yet taken");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid without a result load");

endmodule
